[rtl/core/seik_pkg.sv]
package seik_pkg;

  localparam int CNT_W  = 7;
  localparam int ACC_W  = 36;
  localparam int DIFF_W = 17;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam logic [15:0] LOG2E_HALF_Q16 = 16'd47274;

  localparam logic CFG_INV_ELL_SQ = 1'b0;
  localparam logic CFG_SIG_VAR    = 1'b1;

  localparam logic OP_KERNEL = 1'b0;
  localparam logic OP_GRAD   = 1'b1;

  typedef struct packed {
    logic             op;
    logic [ACC_W-1:0] acc;
    logic [CNT_W-1:0] cnt;
    logic             bank;
  } job_t;

  typedef logic [16:0] exp_tab_t [0:64];

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^-(i/64) in Q1.16, built from a chain of square roots of one half
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] root [0:5];
    logic [63:0] acc;
    root[0] = isqrt64(64'd1 << 63);
    for (int i = 1; i < 6; i++) root[i] = isqrt64(root[i-1] << 32);
    for (int i = 0; i < 64; i++) begin
      acc = 64'd1 << 32;
      for (int b = 0; b < 6; b++) begin
        if (((i >> b) & 1) != 0) acc = (acc * root[5-b] + 64'h8000_0000) >> 32;
      end
      tab[i] = 17'((acc + 64'h8000) >> 16);
    end
    tab[64] = 17'd32768;
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

[rtl/core/se_iso_kernel_eval.sv]
// Squared-exponential isotropic kernel evaluator.
// Input channel (in_*): one coordinate pair per beat, in_end_of_vector on the
// last pair; in_opcode on that last beat picks the result set. Pairs beyond
// VECTOR_LEN are dropped from the sum, the end mark still closes the vector.
// Result channel (out_*): opcode 0 gives one beat (k, k*z, 2k); opcode 1 gives
// one gradient beat per stored coordinate, out_last_result on the final one.
// Config port (cfg_*): write inv_ell_sq (index 0) or sig_var (index 1) while idle.
// Throughput: the front takes one pair per cycle. Each closed vector then runs
// through the back sequencer on one shared 32x24 multiplier: the z, exponent and k
// steps to the kernel beat, then a diff RAM read and multiply per gradient beat.
// Two vectors may be in flight (ping-pong diff banks, two-entry job queue); the
// front holds in_ready low while both banks are claimed.
// Reset (synchronous, rst_n low) empties the queue and output register and sets
// both registers to 1.0. When the receiver stalls, the output register holds its
// beat and the sequencer waits; the front keeps taking pairs for the next vector.
module se_iso_kernel_eval #(
  parameter int VECTOR_LEN = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic signed [15:0]  in_coord_first,
  input  logic signed [15:0]  in_coord_second,
  input  logic                in_end_of_vector,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_result_kind,
  output logic [23:0]         out_kernel_value,
  output logic [31:0]         out_grad_log_length,
  output logic [24:0]         out_grad_log_signal,
  output logic signed [31:0]  out_input_grad,
  output logic [5:0]          out_elem_index,
  output logic                out_last_result
);

  localparam int IW    = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
  localparam int AW    = IW + 1;
  localparam int DEPTH = 2 << IW;

  logic [23:0] inv_ell_sq_r, inv_ell_sq_nxt;
  logic [23:0] sig_var_r, sig_var_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [seik_pkg::DIFF_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [seik_pkg::DIFF_W-1:0] ram_rdata;
  logic                        push;
  seik_pkg::job_t              push_job;
  logic                        pop;
  logic                        q_valid;
  seik_pkg::job_t              q_job;
  logic                        job_done;

  always_comb begin
    inv_ell_sq_nxt = inv_ell_sq_r;
    sig_var_nxt    = sig_var_r;
    if (cfg_we) begin
      case (cfg_index)
        seik_pkg::CFG_INV_ELL_SQ: inv_ell_sq_nxt = cfg_wdata;
        seik_pkg::CFG_SIG_VAR:    sig_var_nxt    = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_ell_sq_r <= 24'd65536;
      sig_var_r    <= 24'd65536;
    end else begin
      inv_ell_sq_r <= inv_ell_sq_nxt;
      sig_var_r    <= sig_var_nxt;
    end
  end

  seik_front #(.VECTOR_LEN(VECTOR_LEN), .AW(AW)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_coord_first   (in_coord_first),
    .in_coord_second  (in_coord_second),
    .in_end_of_vector (in_end_of_vector),
    .job_done         (job_done),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .push             (push),
    .push_job         (push_job)
  );

  seik_ram #(.WIDTH(seik_pkg::DIFF_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  seik_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  seik_back #(.AW(AW)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .inv_ell_sq          (inv_ell_sq_r),
    .sig_var             (sig_var_r),
    .q_valid             (q_valid),
    .q_job               (q_job),
    .q_pop               (pop),
    .job_done            (job_done),
    .ram_re              (ram_re),
    .ram_raddr           (ram_raddr),
    .ram_rdata           (ram_rdata),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_kernel_value    (out_kernel_value),
    .out_grad_log_length (out_grad_log_length),
    .out_grad_log_signal (out_grad_log_signal),
    .out_input_grad      (out_input_grad),
    .out_elem_index      (out_elem_index),
    .out_last_result     (out_last_result)
  );

endmodule

[rtl/core/seik_ram.sv]
module seik_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic [WIDTH-1:0]              wdata,
  input  logic                          re,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic [WIDTH-1:0]              rdata_r
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

endmodule

[rtl/core/seik_queue.sv]
module seik_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  seik_pkg::job_t push_job,
  input  logic          pop,
  output logic          q_valid,
  output seik_pkg::job_t q_job
);

  seik_pkg::job_t ent_r [0:1];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign q_valid = (fill_r != 2'd0);
  assign q_job   = ent_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ pop;
    fill_nxt = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wptr_r] <= push_job;
  end

endmodule

[rtl/core/seik_front.sv]
module seik_front #(
  parameter int VECTOR_LEN = 8,
  parameter int AW = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic signed [15:0]   in_coord_first,
  input  logic signed [15:0]   in_coord_second,
  input  logic                 in_end_of_vector,
  input  logic                 job_done,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_waddr,
  output logic [seik_pkg::DIFF_W-1:0] ram_wdata,
  output logic                 push,
  output seik_pkg::job_t       push_job
);

  localparam int IW = AW - 1;

  logic [seik_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [seik_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       bank_r, bank_nxt;
  logic [1:0]                 outst_r, outst_nxt;

  logic                        take;
  logic                        store;
  logic signed [seik_pkg::DIFF_W-1:0] d;
  logic [seik_pkg::DIFF_W-1:0] mag;
  logic [33:0]                 sq;
  logic [seik_pkg::ACC_W:0]    sum;
  logic [seik_pkg::ACC_W-1:0]  acc_upd;
  logic [seik_pkg::CNT_W-1:0]  cnt_upd;

  // two diff banks: hold off once both are claimed by pending vectors
  assign in_ready = (outst_r != 2'd2);
  assign take     = in_valid && in_ready;

  always_comb begin
    d     = $signed({in_coord_second[15], in_coord_second})
          - $signed({in_coord_first[15], in_coord_first});
    mag   = d[seik_pkg::DIFF_W-1] ? seik_pkg::DIFF_W'(-d) : seik_pkg::DIFF_W'(d);
    sq    = mag * mag;
    store = (cnt_r < seik_pkg::CNT_W'(VECTOR_LEN));
    sum   = {1'b0, acc_r} + {{(seik_pkg::ACC_W-33){1'b0}}, sq};
    acc_upd = acc_r;
    cnt_upd = cnt_r;
    if (store) begin
      acc_upd = sum[seik_pkg::ACC_W] ? seik_pkg::ACC_MAX : sum[seik_pkg::ACC_W-1:0];
      cnt_upd = cnt_r + 1'b1;
    end

    ram_we    = take && store;
    ram_waddr = {bank_r, cnt_r[IW-1:0]};
    ram_wdata = d;

    push          = take && in_end_of_vector;
    push_job.op   = in_opcode;
    push_job.acc  = acc_upd;
    push_job.cnt  = cnt_upd;
    push_job.bank = bank_r;

    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    bank_nxt = bank_r;
    if (take) begin
      if (in_end_of_vector) begin
        acc_nxt  = '0;
        cnt_nxt  = '0;
        bank_nxt = ~bank_r;
      end else begin
        acc_nxt = acc_upd;
        cnt_nxt = cnt_upd;
      end
    end
    outst_nxt = outst_r + {1'b0, push} - {1'b0, job_done};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      cnt_r   <= '0;
      bank_r  <= 1'b0;
      outst_r <= 2'd0;
    end else begin
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      bank_r  <= bank_nxt;
      outst_r <= outst_nxt;
    end
  end

endmodule

[rtl/core/seik_back.sv]
module seik_back #(
  parameter int AW = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [23:0]          inv_ell_sq,
  input  logic [23:0]          sig_var,
  input  logic                 q_valid,
  input  seik_pkg::job_t       q_job,
  output logic                 q_pop,
  output logic                 job_done,
  output logic                 ram_re,
  output logic [AW-1:0]        ram_raddr,
  input  logic [seik_pkg::DIFF_W-1:0] ram_rdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_result_kind,
  output logic [23:0]          out_kernel_value,
  output logic [31:0]          out_grad_log_length,
  output logic [24:0]          out_grad_log_signal,
  output logic signed [31:0]   out_input_grad,
  output logic [5:0]           out_elem_index,
  output logic                 out_last_result
);

  localparam int IW = AW - 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_Z0   = 4'd1;
  localparam logic [3:0] S_Z1   = 4'd2;
  localparam logic [3:0] S_Z2   = 4'd3;
  localparam logic [3:0] S_T    = 4'd4;
  localparam logic [3:0] S_V    = 4'd5;
  localparam logic [3:0] S_W    = 4'd6;
  localparam logic [3:0] S_E    = 4'd7;
  localparam logic [3:0] S_K    = 4'd8;
  localparam logic [3:0] S_KZ   = 4'd9;
  localparam logic [3:0] S_M    = 4'd10;
  localparam logic [3:0] S_G0   = 4'd11;
  localparam logic [3:0] S_G1   = 4'd12;

  logic [3:0]                 state_r, state_nxt;
  seik_pkg::job_t             job_r, job_nxt;
  logic [41:0]                p0_r, p0_nxt;
  logic [23:0]                z_r, z_nxt;
  logic [23:0]                t_r, t_nxt;
  logic [23:0]                k_r, k_nxt;
  logic [31:0]                m_r, m_nxt;
  logic                       neg_r, neg_nxt;
  logic [seik_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic [55:0]                prod_r;

  logic        mul_en;
  logic [31:0] mul_a;
  logic [23:0] mul_b;

  logic        ov_r, ov_nxt;
  logic        kind_r, kind_nxt;
  logic [23:0] kv_r, kv_nxt;
  logic [31:0] gll_r, gll_nxt;
  logic [24:0] gls_r, gls_nxt;
  logic [31:0] ig_r, ig_nxt;
  logic [5:0]  ei_r, ei_nxt;
  logic        lr_r, lr_nxt;

  logic        out_free;
  logic [59:0] full;
  logic [43:0] rz;
  logic [5:0]  tj;
  logic [16:0] tdiff;
  logic [26:0] corr;
  logic [16:0] v;
  logic [4:0]  sh;
  logic [32:0] rnd;
  logic [32:0] esh;
  logic [16:0] e;
  logic [40:0] kr;
  logic [32:0] kz;
  logic [47:0] mr;
  logic [seik_pkg::DIFF_W-1:0] mag;
  logic [40:0] g;
  logic [31:0] enc;
  logic [seik_pkg::CNT_W-1:0] idx_inc;

  assign out_free = !ov_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    p0_nxt    = p0_r;
    z_nxt     = z_r;
    t_nxt     = t_r;
    k_nxt     = k_r;
    m_nxt     = m_r;
    neg_nxt   = neg_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    job_done  = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = {job_r.bank, idx_r[IW-1:0]};
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;

    ov_nxt   = ov_r && !out_ready;
    kind_nxt = kind_r;
    kv_nxt   = kv_r;
    gll_nxt  = gll_r;
    gls_nxt  = gls_r;
    ig_nxt   = ig_r;
    ei_nxt   = ei_r;
    lr_nxt   = lr_r;

    full  = {prod_r[41:0], 18'd0} + {18'd0, p0_r};
    rz    = 44'((full + 60'h8000) >> 16);
    tj    = t_r[15:10];
    tdiff = seik_pkg::EXP_TAB[tj] - seik_pkg::EXP_TAB[{1'b0, tj} + 7'd1];
    corr  = 27'((prod_r[26:0] + 27'd512) >> 10);
    v     = seik_pkg::EXP_TAB[tj] - corr[16:0];
    sh    = t_r[20:16];
    rnd   = 33'd1 << (sh - 5'd1);
    esh   = ({16'd0, v} + rnd) >> sh;
    if (t_r[23:21] != 3'd0) e = '0;
    else if (sh == 5'd0) e = v;
    else e = esh[16:0];
    kr    = prod_r[40:0] + 41'h8000;
    kz    = 33'((prod_r[47:0] + 48'h8000) >> 16);
    mr    = prod_r[47:0] + 48'h8000;
    mag   = ram_rdata[seik_pkg::DIFF_W-1] ? seik_pkg::DIFF_W'(-ram_rdata) : ram_rdata;
    g     = 41'((prod_r[48:0] + 49'h80) >> 8);
    if (neg_r) enc = (g > 41'h0_8000_0000) ? 32'h8000_0000 : 32'(-g[31:0]);
    else       enc = (g > 41'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : g[31:0];
    idx_inc = idx_r + 1'b1;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          state_nxt = S_Z0;
        end
      end
      S_Z0: begin
        mul_en    = 1'b1;
        mul_a     = {14'd0, job_r.acc[17:0]};
        mul_b     = inv_ell_sq;
        state_nxt = S_Z1;
      end
      S_Z1: begin
        p0_nxt    = prod_r[41:0];
        mul_en    = 1'b1;
        mul_a     = {14'd0, job_r.acc[35:18]};
        mul_b     = inv_ell_sq;
        state_nxt = S_Z2;
      end
      S_Z2: begin
        z_nxt     = (rz[43:24] != '0) ? 24'hFF_FFFF : rz[23:0];
        state_nxt = S_T;
      end
      S_T: begin
        mul_en    = 1'b1;
        mul_a     = {8'd0, z_r};
        mul_b     = {8'd0, seik_pkg::LOG2E_HALF_Q16};
        state_nxt = S_V;
      end
      S_V: begin
        t_nxt     = 24'((prod_r[39:0] + 40'h8000) >> 16);
        state_nxt = S_W;
      end
      S_W: begin
        mul_en    = 1'b1;
        mul_a     = {15'd0, tdiff};
        mul_b     = {14'd0, t_r[9:0]};
        state_nxt = S_E;
      end
      S_E: begin
        mul_en    = 1'b1;
        mul_a     = {15'd0, e};
        mul_b     = sig_var;
        state_nxt = S_K;
      end
      S_K: begin
        k_nxt  = kr[39:16];
        mul_en = 1'b1;
        mul_a  = {8'd0, kr[39:16]};
        if (job_r.op == seik_pkg::OP_KERNEL) begin
          mul_b     = z_r;
          state_nxt = S_KZ;
        end else begin
          mul_b     = inv_ell_sq;
          state_nxt = S_M;
        end
      end
      S_KZ: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          kind_nxt  = 1'b0;
          kv_nxt    = k_r;
          gll_nxt   = kz[32] ? 32'hFFFF_FFFF : kz[31:0];
          gls_nxt   = {k_r, 1'b0};
          ig_nxt    = '0;
          ei_nxt    = '0;
          lr_nxt    = 1'b1;
          job_done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_M: begin
        m_nxt     = mr[47:16];
        idx_nxt   = '0;
        ram_re    = 1'b1;
        ram_raddr = {job_r.bank, {IW{1'b0}}};
        state_nxt = S_G0;
      end
      S_G0: begin
        neg_nxt   = ram_rdata[seik_pkg::DIFF_W-1];
        mul_en    = 1'b1;
        mul_a     = m_r;
        mul_b     = {{(24-seik_pkg::DIFF_W){1'b0}}, mag};
        state_nxt = S_G1;
      end
      S_G1: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          kind_nxt = 1'b1;
          kv_nxt   = k_r;
          gll_nxt  = '0;
          gls_nxt  = '0;
          ig_nxt   = enc;
          ei_nxt   = idx_r[5:0];
          lr_nxt   = (idx_inc == job_r.cnt);
          if (idx_inc == job_r.cnt) begin
            job_done  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            ram_re    = 1'b1;
            ram_raddr = {job_r.bank, idx_inc[IW-1:0]};
            state_nxt = S_G0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    p0_r   <= p0_nxt;
    z_r    <= z_nxt;
    t_r    <= t_nxt;
    k_r    <= k_nxt;
    m_r    <= m_nxt;
    neg_r  <= neg_nxt;
    idx_r  <= idx_nxt;
    kind_r <= kind_nxt;
    kv_r   <= kv_nxt;
    gll_r  <= gll_nxt;
    gls_r  <= gls_nxt;
    ig_r   <= ig_nxt;
    ei_r   <= ei_nxt;
    lr_r   <= lr_nxt;
    if (mul_en) prod_r <= mul_a * mul_b;
  end

  assign out_valid           = ov_r;
  assign out_result_kind     = kind_r;
  assign out_kernel_value    = kv_r;
  assign out_grad_log_length = gll_r;
  assign out_grad_log_signal = gls_r;
  assign out_input_grad      = ig_r;
  assign out_elem_index      = ei_r;
  assign out_last_result     = lr_r;

endmodule

[rtl/core/seik_checker.sv]
module seik_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_result_kind,
  input logic [23:0]        out_kernel_value,
  input logic [31:0]        out_grad_log_length,
  input logic [24:0]        out_grad_log_signal,
  input logic signed [31:0] out_input_grad,
  input logic [5:0]         out_elem_index,
  input logic               out_last_result
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kernel_value)
      && $stable(out_input_grad) && $stable(out_elem_index))
    else $error("result beat changed while stalled");

  a_kernel_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_kind |-> out_last_result && out_elem_index == 6'd0
      && out_input_grad == 32'sd0 && out_grad_log_signal == {out_kernel_value, 1'b0})
    else $error("malformed kernel result");

  a_grad_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind |-> out_grad_log_length == 32'd0
      && out_grad_log_signal == 25'd0)
    else $error("malformed gradient element");

  a_grad_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_result_kind && !out_last_result
      |=> !out_valid || (out_result_kind && out_elem_index == $past(out_elem_index) + 6'd1))
    else $error("gradient elements out of order");

endmodule

bind se_iso_kernel_eval seik_checker u_seik_checker (.*);
